@@ rtl/srma_pkg.sv @@
// Shared types and constants for the sparse row merge accumulator.
// No dependencies; used by srma_front, srma_back, the top level and the testbench.
`default_nettype none
package srma_pkg;

   localparam int LANES_DEFAULT      = 4;
   localparam int LANE_DEPTH_DEFAULT = 8;

   localparam int LANE_FIELD_W  = 2;
   localparam int COUNT_FIELD_W = 3;
   localparam int DATA_W        = 32;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

   typedef enum logic [1:0] {
      CMD_BEGIN = 2'd0,
      CMD_SCALE = 2'd1,
      CMD_PUSH  = 2'd2,
      CMD_CLOSE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETTLE,
      ST_EVAL,
      ST_MERGE
   } state_type;

   typedef struct packed {
      cmd_type                  cmd;
      logic                     lane_ok;
      logic [LANE_FIELD_W-1:0]  lane;
      logic [COUNT_FIELD_W-1:0] count;
      logic [DATA_W-1:0]        col;
      logic [DATA_W-1:0]        val;
   } item_type;

endpackage
`default_nettype wire

@@ rtl/srma_ram.sv @@
// Generic single write port RAM with registered read.
// No dependencies.
`default_nettype none
module srma_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

@@ rtl/srma_front.sv @@
// Front end: takes command transfers, classifies them and queues them.
// Depends on srma_pkg.
`default_nettype none
module srma_front #(
   parameter int LANES = srma_pkg::LANES_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output      logic              req_tready,
   input  wire logic [71:0]       req_tdata,
   input  wire logic [1:0]        req_tuser,
   output      logic              item_valid,
   output      srma_pkg::item_type item,
   input  wire logic              item_pop
);

   localparam int CW = $clog2(srma_pkg::QUEUE_DEPTH + 1);

   srma_pkg::item_type entry_ff [srma_pkg::QUEUE_DEPTH];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   srma_pkg::item_type new_item;
   logic [srma_pkg::COUNT_FIELD_W-1:0] raw_count;
   logic               push;

   assign req_tready = cnt_ff != CW'(srma_pkg::QUEUE_DEPTH);
   assign push       = req_tvalid && req_tready;
   assign item_valid = cnt_ff != '0;
   assign item       = entry_ff[rd_ptr_ff];
   assign raw_count  = req_tdata[4:2];

   always_comb begin
      new_item.cmd     = srma_pkg::cmd_type'(req_tuser);
      new_item.lane    = req_tdata[1:0];
      new_item.lane_ok = 32'(req_tdata[1:0]) < 32'(LANES);
      new_item.count   = (32'(raw_count) > 32'(LANES)) ?
                         srma_pkg::COUNT_FIELD_W'(LANES) : raw_count;
      new_item.col     = req_tdata[36:5];
      new_item.val     = req_tdata[68:37];
   end

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = item_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + CW'(push) - CW'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule
`default_nettype wire

@@ rtl/srma_back.sv @@
// Back end: lane FIFOs, head selection, Q16.16 product and accumulation.
// Depends on srma_pkg and srma_ram.
`default_nettype none
module srma_back #(
   parameter int LANES      = srma_pkg::LANES_DEFAULT,
   parameter int LANE_DEPTH = srma_pkg::LANE_DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_valid,
   input  wire srma_pkg::item_type item,
   output      logic               item_pop,
   output      logic               rsp_tvalid,
   input  wire logic               rsp_tready,
   output      logic [63:0]        rsp_tdata,
   output      logic               rsp_tlast,
   output      logic [1:0]         rsp_tuser
);

   localparam int LW = $clog2(LANES);
   localparam int AW = $clog2(LANE_DEPTH);
   localparam int FW = $clog2(LANE_DEPTH + 1);
   localparam int OW = $clog2(LANES + 1);

   srma_pkg::state_type state_ff, state_in;

   logic [FW-1:0] fill_ff  [LANES];
   logic [FW-1:0] fill_in  [LANES];
   logic [AW-1:0] head_ff  [LANES];
   logic [AW-1:0] head_in  [LANES];
   logic [31:0]   scale_ff [LANES];
   logic [31:0]   scale_in [LANES];
   logic [LANES-1:0] closed_ff, closed_in;
   logic [OW-1:0] open_ff, open_in;
   logic          busy_ff, busy_in;
   logic [31:0]   acc_col_ff, acc_col_in;
   logic [31:0]   acc_sum_ff, acc_sum_in;
   logic          acc_valid_ff, acc_valid_in;
   logic          acc_clip_ff, acc_clip_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [31:0]   pcol_ff, pcol_in;

   logic          out_valid_ff, out_valid_in;
   logic [31:0]   out_col_ff, out_col_in;
   logic [31:0]   out_val_ff, out_val_in;
   logic          out_last_ff, out_last_in;
   logic          out_rej_ff, out_rej_in;
   logic          out_sat_ff, out_sat_in;

   logic [63:0]   rd_data [LANES];
   logic [LANES-1:0] wr_en;
   logic [AW-1:0] wr_addr;

   logic          out_free, advance;
   logic [LW-1:0] lane_ix;
   logic          stall, have;
   logic [LW-1:0] best;
   logic [31:0]   best_col;
   logic [FW:0]   tail_sum;
   logic signed [63:0] q_full;
   logic signed [31:0] q_sat;
   logic          q_clip;
   logic signed [32:0] sum_full;
   logic signed [31:0] sum_sat;
   logic          sum_clip;

   assign out_free = !out_valid_ff || rsp_tready;
   assign lane_ix  = LW'(item.lane);
   assign wr_addr  = AW'((tail_sum >= (FW+1)'(LANE_DEPTH)) ?
                         tail_sum - (FW+1)'(LANE_DEPTH) : tail_sum);
   assign tail_sum = (FW+1)'(head_ff[lane_ix]) + (FW+1)'(fill_ff[lane_ix]);

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      srma_ram #(.WIDTH(64), .DEPTH(LANE_DEPTH)) u_ram (
         .clock   (clock),
         .wr_en   (wr_en[g]),
         .wr_addr (wr_addr),
         .wr_data ({item.col, item.val}),
         .rd_addr (head_ff[g]),
         .rd_data (rd_data[g])
      );
   end

   // head selection over open lanes, lowest lane wins ties
   always_comb begin
      stall    = 1'b0;
      have     = 1'b0;
      best     = '0;
      best_col = '0;
      for (int i = 0; i < LANES; i++) begin
         if (32'(i) < 32'(open_ff)) begin
            if (fill_ff[i] == '0) begin
               if (!closed_ff[i]) stall = 1'b1;
            end else if (!have || rd_data[i][63:32] < best_col) begin
               have     = 1'b1;
               best     = LW'(i);
               best_col = rd_data[i][63:32];
            end
         end
      end
   end

   always_comb begin
      q_full = prod_ff >>> 16;
      q_clip = 1'b0;
      q_sat  = q_full[31:0];
      if (q_full > 64'(srma_pkg::Q_MAX)) begin
         q_sat  = srma_pkg::Q_MAX;
         q_clip = 1'b1;
      end else if (q_full < 64'(srma_pkg::Q_MIN)) begin
         q_sat  = srma_pkg::Q_MIN;
         q_clip = 1'b1;
      end
      sum_full = 33'(signed'(acc_sum_ff)) + 33'(q_sat);
      sum_clip = 1'b0;
      sum_sat  = sum_full[31:0];
      if (sum_full > 33'(srma_pkg::Q_MAX)) begin
         sum_sat  = srma_pkg::Q_MAX;
         sum_clip = 1'b1;
      end else if (sum_full < 33'(srma_pkg::Q_MIN)) begin
         sum_sat  = srma_pkg::Q_MIN;
         sum_clip = 1'b1;
      end
   end

   // advance: the current state's work completes this cycle
   always_comb begin
      advance = 1'b1;
      unique case (state_ff)
         srma_pkg::ST_IDLE: begin
            advance = item_valid;
            if (item.cmd == srma_pkg::CMD_PUSH && item.lane_ok && !closed_ff[lane_ix] &&
                fill_ff[lane_ix] == FW'(LANE_DEPTH) && !out_free) advance = 1'b0;
         end
         srma_pkg::ST_SETTLE: advance = 1'b1;
         srma_pkg::ST_EVAL: begin
            if (busy_ff && !stall && !have && acc_valid_ff && !out_free) advance = 1'b0;
         end
         srma_pkg::ST_MERGE: begin
            if (acc_valid_ff && pcol_ff > acc_col_ff && !out_free) advance = 1'b0;
         end
         default: advance = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srma_pkg::ST_IDLE:   if (advance) state_in = srma_pkg::ST_SETTLE;
         srma_pkg::ST_SETTLE: state_in = srma_pkg::ST_EVAL;
         srma_pkg::ST_EVAL: begin
            if (advance) begin
               if (busy_ff && have && !stall) state_in = srma_pkg::ST_MERGE;
               else                           state_in = srma_pkg::ST_IDLE;
            end
         end
         srma_pkg::ST_MERGE:  if (advance) state_in = srma_pkg::ST_EVAL;
         default:             state_in = srma_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      fill_in      = fill_ff;
      head_in      = head_ff;
      scale_in     = scale_ff;
      closed_in    = closed_ff;
      open_in      = open_ff;
      busy_in      = busy_ff;
      acc_col_in   = acc_col_ff;
      acc_sum_in   = acc_sum_ff;
      acc_valid_in = acc_valid_ff;
      acc_clip_in  = acc_clip_ff;
      prod_in      = prod_ff;
      pcol_in      = pcol_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_col_in   = out_col_ff;
      out_val_in   = out_val_ff;
      out_last_in  = out_last_ff;
      out_rej_in   = out_rej_ff;
      out_sat_in   = out_sat_ff;
      wr_en        = '0;
      item_pop     = 1'b0;
      unique case (state_ff)
         srma_pkg::ST_IDLE: begin
            if (advance) begin
               item_pop = 1'b1;
               unique case (item.cmd)
                  srma_pkg::CMD_BEGIN: begin
                     if (!busy_ff) begin
                        open_in = OW'(item.count);
                        for (int i = 0; i < LANES; i++) begin
                           closed_in[i] = !(32'(i) < 32'(item.count));
                        end
                        acc_valid_in = 1'b0;
                        acc_clip_in  = 1'b0;
                        acc_col_in   = '0;
                        acc_sum_in   = '0;
                        busy_in      = 1'b1;
                     end
                  end
                  srma_pkg::CMD_SCALE: begin
                     if (item.lane_ok) scale_in[lane_ix] = item.val;
                  end
                  srma_pkg::CMD_PUSH: begin
                     if (item.lane_ok && !closed_ff[lane_ix]) begin
                        if (fill_ff[lane_ix] == FW'(LANE_DEPTH)) begin
                           out_valid_in = 1'b1;
                           out_col_in   = '0;
                           out_val_in   = '0;
                           out_last_in  = 1'b0;
                           out_rej_in   = 1'b1;
                           out_sat_in   = 1'b0;
                        end else begin
                           wr_en[lane_ix]   = 1'b1;
                           fill_in[lane_ix] = fill_ff[lane_ix] + FW'(1);
                        end
                     end
                  end
                  srma_pkg::CMD_CLOSE: begin
                     if (item.lane_ok) closed_in[lane_ix] = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         srma_pkg::ST_SETTLE: ;
         srma_pkg::ST_EVAL: begin
            if (advance && busy_ff) begin
               if (!stall && !have) begin
                  if (acc_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_col_in   = acc_col_ff;
                     out_val_in   = acc_sum_ff;
                     out_last_in  = 1'b1;
                     out_rej_in   = 1'b0;
                     out_sat_in   = acc_clip_ff;
                  end
                  busy_in      = 1'b0;
                  acc_valid_in = 1'b0;
                  acc_clip_in  = 1'b0;
                  acc_col_in   = '0;
                  acc_sum_in   = '0;
                  open_in      = '0;
                  closed_in    = '1;
               end else if (have && !stall) begin
                  prod_in       = signed'(scale_ff[best]) * signed'(rd_data[best][31:0]);
                  pcol_in       = best_col;
                  head_in[best] = (head_ff[best] == AW'(LANE_DEPTH - 1)) ?
                                  '0 : head_ff[best] + AW'(1);
                  fill_in[best] = fill_ff[best] - FW'(1);
               end
            end
         end
         srma_pkg::ST_MERGE: begin
            if (advance) begin
               if (!acc_valid_ff || pcol_ff > acc_col_ff) begin
                  if (acc_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_col_in   = acc_col_ff;
                     out_val_in   = acc_sum_ff;
                     out_last_in  = 1'b0;
                     out_rej_in   = 1'b0;
                     out_sat_in   = acc_clip_ff;
                  end
                  acc_valid_in = 1'b1;
                  acc_col_in   = pcol_ff;
                  acc_sum_in   = q_sat;
                  acc_clip_in  = q_clip;
               end else begin
                  acc_sum_in  = sum_sat;
                  acc_clip_in = acc_clip_ff || q_clip || sum_clip;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srma_pkg::ST_IDLE;
         for (int i = 0; i < LANES; i++) begin
            fill_ff[i]  <= '0;
            head_ff[i]  <= '0;
            scale_ff[i] <= '0;
         end
         closed_ff    <= '1;
         open_ff      <= '0;
         busy_ff      <= 1'b0;
         acc_col_ff   <= '0;
         acc_sum_ff   <= '0;
         acc_valid_ff <= 1'b0;
         acc_clip_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
         scale_ff     <= scale_in;
         closed_ff    <= closed_in;
         open_ff      <= open_in;
         busy_ff      <= busy_in;
         acc_col_ff   <= acc_col_in;
         acc_sum_ff   <= acc_sum_in;
         acc_valid_ff <= acc_valid_in;
         acc_clip_ff  <= acc_clip_in;
         out_valid_ff <= out_valid_in;
      end
      prod_ff     <= prod_in;
      pcol_ff     <= pcol_in;
      out_col_ff  <= out_col_in;
      out_val_ff  <= out_val_in;
      out_last_ff <= out_last_in;
      out_rej_ff  <= out_rej_in;
      out_sat_ff  <= out_sat_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_val_ff, out_col_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = {out_sat_ff, out_rej_ff};

endmodule
`default_nettype wire

@@ rtl/sparse_row_merge_accumulate.sv @@
// Sparse row merge accumulator, top level.
// Request channel (req_*) carries commands: begin task, set lane scale,
// push (column, Q16.16 value) element, close lane. Response channel (rsp_*)
// carries merged (column, sum) entries, tlast on the final entry of a task,
// plus reject and saturation flags in tuser.
// A two-entry command queue feeds the merge engine, which runs after each
// command until it stalls. Each command passes through the idle, settle and
// eval states; each merged element adds eval (head select and multiply) and
// merge (accumulate), set by the registered read of the lane RAMs and the multiplier register.
// With the engine free, a reject is registered in the idle state that takes
// its command, a final entry in the eval state that finds nothing left to
// merge, and a previous entry in the merge state; queued commands wait their turn.
// Reset empties all lanes, clears scales and ends any task; the lane RAMs
// are not cleared and need no clearing pass.
// When the receiver stalls with a response held, the engine waits in place once
// it has another response to send, and the queue fills, then req_tready falls.
// Depends on srma_pkg, srma_front, srma_back, srma_ram.
`default_nettype none
module sparse_row_merge_accumulate #(
   parameter int LANES      = srma_pkg::LANES_DEFAULT,
   parameter int LANE_DEPTH = srma_pkg::LANE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [71:0] req_tdata,  // lane[1:0], lane_count[4:2], col_idx[36:5], value[68:37]
   input  wire logic [1:0]  req_tuser,  // cmd
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [63:0] rsp_tdata,  // out_col[31:0], out_value[63:32]
   output      logic        rsp_tlast,
   output      logic [1:0]  rsp_tuser   // rejected[0], saturated[1]
);

   logic               item_valid;
   logic               item_pop;
   srma_pkg::item_type item;

   srma_front #(.LANES(LANES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   srma_back #(.LANES(LANES), .LANE_DEPTH(LANE_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

@@ tb/sparse_row_merge_accumulate_tb.sv @@
// Testbench for sparse_row_merge_accumulate: directed and random merge tasks,
// checked transfer by transfer against a behavioural merger kept in this file.
// Depends on srma_pkg and the RTL top level.
`timescale 1ns / 1ps
module sparse_row_merge_accumulate_tb;

   localparam int NL = 4;
   localparam int DEPTH = 8;
   localparam int STALL_LIMIT = 4000;

   typedef struct {
      srma_pkg::cmd_type cmd;
      logic [1:0]  lane;
      logic [2:0]  cnt;
      logic [31:0] col;
      logic [31:0] val;
      bit          drain;
      int          phase;
   } command_type;

   typedef struct {
      logic [31:0] col;
      logic [31:0] val;
      logic        last;
      logic        rej;
      logic        sat;
   } entry_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;

   command_type pending_cmds[$];
   entry_type   expected_entries[$];

   // merger state
   logic [31:0] m_cols[NL][DEPTH];
   logic [31:0] m_vals[NL][DEPTH];
   int          m_fill[NL];
   int          m_head[NL];
   logic [31:0] m_scale[NL];
   logic [NL-1:0] m_closed;
   int          m_open;
   logic [31:0] m_acc_col;
   logic [31:0] m_acc_sum;
   bit          m_acc_valid, m_busy, m_acc_clip;

   int  gen_phase = 0;
   int  cur_phase = 0;
   bit  req_done = 0;
   int  failures = 0;
   int  n_req = 0, n_rsp = 0, n_rej = 0, n_sat = 0, n_last = 0;
   int  quiet_cycles = 0;

   sparse_row_merge_accumulate dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );

   always #10 clock = ~clock;

   function automatic void expect_entry(logic [31:0] c, logic [31:0] v, logic l, logic r,
                                        logic s);
      entry_type e;
      e.col = c; e.val = v; e.last = l; e.rej = r; e.sat = s;
      expected_entries = {expected_entries, e};
   endfunction

   function automatic logic [31:0] clip_q(longint x, ref bit clipped);
      if (x > 64'sd2147483647) begin
         clipped = 1;
         return 32'h7FFF_FFFF;
      end
      if (x < -64'sd2147483648) begin
         clipped = 1;
         return 32'h8000_0000;
      end
      return x[31:0];
   endfunction

   function automatic void run_merge();
      int finished, best, i;
      logic [31:0] best_col, c, q;
      bit stall, have, clipped;
      longint p;
      while (m_busy) begin
         finished = 0; best = 0; best_col = 0; stall = 0; have = 0;
         for (i = 0; i < m_open && i < NL; i++) begin
            if (m_fill[i] == 0) begin
               if (m_closed[i]) finished++;
               else stall = 1;
            end else begin
               c = m_cols[i][m_head[i]];
               if (!have || c < best_col) begin
                  have = 1; best_col = c; best = i;
               end
            end
         end
         if (finished == m_open) begin
            if (m_acc_valid) expect_entry(m_acc_col, m_acc_sum, 1, 0, m_acc_clip);
            m_busy = 0; m_acc_valid = 0; m_acc_clip = 0;
            m_acc_col = 0; m_acc_sum = 0; m_open = 0; m_closed = '1;
            break;
         end
         if (stall || !have) break;
         p = longint'($signed(m_scale[best])) * longint'($signed(m_vals[best][m_head[best]]));
         clipped = 0;
         q = clip_q(p >>> 16, clipped);
         if (!m_acc_valid) begin
            m_acc_valid = 1; m_acc_col = best_col; m_acc_sum = q; m_acc_clip = clipped;
         end else if (best_col > m_acc_col) begin
            expect_entry(m_acc_col, m_acc_sum, 0, 0, m_acc_clip);
            m_acc_col = best_col; m_acc_sum = q; m_acc_clip = clipped;
         end else begin
            m_acc_sum = clip_q(longint'($signed(m_acc_sum)) + longint'($signed(q)), clipped);
            if (clipped) m_acc_clip = 1;
         end
         m_head[best] = (m_head[best] + 1) % DEPTH;
         m_fill[best]--;
      end
   endfunction

   function automatic void apply_command(srma_pkg::cmd_type cmd, int lane, int cnt,
                                         logic [31:0] col, logic [31:0] val);
      int i;
      if (cmd == srma_pkg::CMD_BEGIN) begin
         if (!m_busy) begin
            if (cnt > NL) cnt = NL;
            m_open = cnt;
            m_closed = '1;
            for (i = 0; i < cnt; i++) m_closed[i] = 0;
            m_acc_valid = 0; m_acc_clip = 0; m_acc_col = 0; m_acc_sum = 0;
            m_busy = 1;
         end
      end else if (cmd == srma_pkg::CMD_SCALE) begin
         m_scale[lane] = val;
      end else if (cmd == srma_pkg::CMD_PUSH) begin
         if (!m_closed[lane]) begin
            if (m_fill[lane] >= DEPTH) begin
               expect_entry(0, 0, 0, 1, 0);
            end else begin
               i = (m_head[lane] + m_fill[lane]) % DEPTH;
               m_cols[lane][i] = col;
               m_vals[lane][i] = val;
               m_fill[lane]++;
            end
         end
      end else begin
         m_closed[lane] = 1;
      end
      run_merge();
   endfunction

   function automatic void add_cmd(srma_pkg::cmd_type cmd, int lane, int cnt,
                                   logic [31:0] col, logic [31:0] val);
      command_type c;
      c.cmd = cmd; c.lane = 2'(lane); c.cnt = 3'(cnt); c.col = col; c.val = val;
      c.drain = 0; c.phase = gen_phase;
      pending_cmds = {pending_cmds, c};
   endfunction

   function automatic void add_drain();
      command_type c;
      c = '{cmd: srma_pkg::CMD_BEGIN, lane: 0, cnt: 0, col: 0, val: 0, drain: 1,
            phase: gen_phase};
      pending_cmds = {pending_cmds, c};
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
         2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      endcase
   endfunction

   function automatic int random_task();
      int n, nl, i, l, total, added;
      int left[NL];
      logic [31:0] colv[NL];
      added = 0;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      nl = (n > NL) ? NL : n;
      add_cmd(srma_pkg::CMD_BEGIN, 0, n, $urandom(), $urandom());
      added++;
      total = 0;
      for (l = 0; l < nl; l++) begin
         case ($urandom_range(0, 3))
            0: add_cmd(srma_pkg::CMD_SCALE, l, $urandom(), $urandom(), 32'h0001_0000);
            1: add_cmd(srma_pkg::CMD_SCALE, l, $urandom(), $urandom(), $urandom());
            default: add_cmd(srma_pkg::CMD_SCALE, l, $urandom(), $urandom(), pick_value());
         endcase
         added++;
         left[l] = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 11) : $urandom_range(0, 6);
         colv[l] = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 20);
         total += left[l];
      end
      while (total > 0) begin
         l = $urandom_range(0, nl - 1);
         if (left[l] == 0) continue;
         if ($urandom_range(0, 19) == 0) begin
            add_cmd(srma_pkg::cmd_type'($urandom_range(1, 3)), $urandom_range(0, 3),
                    $urandom(), $urandom(), $urandom());
            added++;
         end
         add_cmd(srma_pkg::CMD_PUSH, l, $urandom(), colv[l], pick_value());
         added++;
         if ($urandom_range(0, 9) == 0) colv[l] = $urandom();
         else colv[l] = colv[l] + $urandom_range(0, 3);
         left[l]--;
         total--;
      end
      for (i = 0; i < nl; i++) begin
         add_cmd(srma_pkg::CMD_CLOSE, (i + n) % nl, $urandom(), $urandom(), $urandom());
         added++;
      end
      return added;
   endfunction

   initial begin
      int i, made, tasks;
      m_closed = '1;
      m_open = 0; m_busy = 0; m_acc_valid = 0; m_acc_clip = 0;
      m_acc_col = 0; m_acc_sum = 0;
      for (i = 0; i < NL; i++) begin
         m_fill[i] = 0; m_head[i] = 0; m_scale[i] = 0;
      end

      // directed: idle pushes, empty task, clamped count, saturation, overflow
      add_cmd(srma_pkg::CMD_PUSH, 1, 0, 32'd5, 32'h0001_0000);
      add_cmd(srma_pkg::CMD_BEGIN, 0, 0, 0, 0);
      add_cmd(srma_pkg::CMD_BEGIN, 0, 7, 0, 0);
      add_cmd(srma_pkg::CMD_BEGIN, 0, 2, 0, 0);
      add_cmd(srma_pkg::CMD_SCALE, 0, 0, 0, 32'h8000_0000);
      add_cmd(srma_pkg::CMD_SCALE, 1, 0, 0, 32'h7FFF_FFFF);
      add_cmd(srma_pkg::CMD_SCALE, 2, 0, 0, 32'h8000_0000);
      add_cmd(srma_pkg::CMD_SCALE, 3, 0, 0, 32'h7FFF_FFFF);
      add_cmd(srma_pkg::CMD_CLOSE, 1, 0, 0, 0);
      add_cmd(srma_pkg::CMD_CLOSE, 1, 0, 0, 0);
      add_cmd(srma_pkg::CMD_CLOSE, 3, 0, 0, 0);
      add_cmd(srma_pkg::CMD_CLOSE, 2, 0, 0, 0);
      add_cmd(srma_pkg::CMD_PUSH, 3, 0, 32'hFFFF_FFFE, 32'h8000_0000);
      add_cmd(srma_pkg::CMD_PUSH, 0, 0, 32'd0, 32'h8000_0000);
      add_cmd(srma_pkg::CMD_PUSH, 0, 0, 32'd0, 32'h7FFF_FFFF);
      add_cmd(srma_pkg::CMD_SCALE, 0, 0, 0, 32'h0001_0000);
      add_cmd(srma_pkg::CMD_PUSH, 0, 0, 32'd9, 32'hFFFF_FFFF);
      add_cmd(srma_pkg::CMD_PUSH, 0, 0, 32'd3, 32'd7);
      add_cmd(srma_pkg::CMD_PUSH, 0, 0, 32'hFFFF_FFFE, 32'h7FFF_FFFF);
      add_cmd(srma_pkg::CMD_CLOSE, 0, 0, 0, 0);
      add_drain();
      add_cmd(srma_pkg::CMD_BEGIN, 0, 2, 0, 0);
      for (i = 0; i < 9; i++) add_cmd(srma_pkg::CMD_PUSH, 1, 0, i, 32'h0002_0000);
      add_cmd(srma_pkg::CMD_CLOSE, 0, 0, 0, 0);
      add_cmd(srma_pkg::CMD_CLOSE, 1, 0, 0, 0);

      made = 32;
      tasks = 0;
      while (made < 470) begin
         gen_phase = (made * 3) / 470;
         made += random_task();
         tasks++;
         if (tasks % 12 == 0) add_drain();
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      while (pending_cmds.size() > 0 || expected_entries.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("%0d commands sent, %0d responses checked (%0d rejects, %0d saturated, %0d ends)",
               n_req, n_rsp, n_rej, n_sat, n_last);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_done) begin
         req_done = 0;
         if (pending_cmds.size() > 0 && pending_cmds[0].drain) begin
            if (expected_entries.size() == 0) pending_cmds.delete(0);
            req_tvalid <= 0;
         end else if (pending_cmds.size() > 0 &&
                      $urandom_range(0, 99) >= (cur_phase == 0 ? 37 :
                                                cur_phase == 1 ? 71 : 0)) begin
            cur_phase = pending_cmds[0].phase;
            req_tdata <= {3'b0, pending_cmds[0].val, pending_cmds[0].col,
                          pending_cmds[0].cnt, pending_cmds[0].lane};
            req_tuser <= pending_cmds[0].cmd;
            req_tvalid <= 1;
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= $urandom_range(0, 99) >= (cur_phase == 0 ? 71 : cur_phase == 1 ? 37 : 0);
   end

   // transfer monitor and checker
   always @(posedge clock) begin
      entry_type e;
      if (!reset) begin
         quiet_cycles++;
         if (req_tvalid && req_tready) begin
            quiet_cycles = 0;
            req_done = 1;
            n_req++;
            pending_cmds.delete(0);
            apply_command(srma_pkg::cmd_type'(req_tuser), int'(req_tdata[1:0]),
                          int'(req_tdata[4:2]), req_tdata[36:5], req_tdata[68:37]);
         end
         if (rsp_tvalid && rsp_tready) begin
            quiet_cycles = 0;
            n_rsp++;
            if (rsp_tuser[0]) n_rej++;
            if (rsp_tuser[1]) n_sat++;
            if (rsp_tlast) n_last++;
            if (expected_entries.size() == 0) begin
               failures++;
               $display("%t: unexpected response col=%h value=%h last=%b user=%b", $realtime,
                        rsp_tdata[31:0], rsp_tdata[63:32], rsp_tlast, rsp_tuser);
            end else begin
               e = expected_entries[0];
               expected_entries.delete(0);
               if (rsp_tdata[31:0] !== e.col || rsp_tdata[63:32] !== e.val ||
                   rsp_tlast !== e.last || rsp_tuser[0] !== e.rej || rsp_tuser[1] !== e.sat)
               begin
                  failures++;
                  $display("%t: mismatch expected col=%h value=%h last=%b rej=%b sat=%b",
                           $realtime, e.col, e.val, e.last, e.rej, e.sat);
                  $display("%t:          actual   col=%h value=%h last=%b rej=%b sat=%b",
                           $realtime, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tlast,
                           rsp_tuser[0], rsp_tuser[1]);
               end
            end
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

endmodule

@@ filelist.f @@
rtl/srma_pkg.sv
rtl/srma_ram.sv
rtl/srma_front.sv
rtl/srma_back.sv
rtl/sparse_row_merge_accumulate.sv
tb/sparse_row_merge_accumulate_tb.sv
